/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the Coulomb force unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while arst_n is low.
`define CDSF_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while arst_n is low.
`define CDSF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/cdsf_pkg.sv */
// Shared widths, constants, types and saturation helper of the Coulomb force unit.
package cdsf_pkg;

	localparam int POS_W       = 32;
	localparam int CHG_W       = 16;
	localparam int ACC_W       = 48;
	localparam int IDX_W       = 6;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 200;
	localparam int DELTA_W     = 33;
	localparam int QM_W        = 31;
	localparam int D_W         = 34;
	localparam int S_W         = 66;
	localparam int P_W         = 68;
	localparam int DIV_W       = 102;
	localparam int QUO_W       = 48;

	localparam logic [ACC_W-1:0]        MAG_CAP = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SAT_HI  = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_LO  = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] acc,
		input logic [ACC_W-1:0]        mag,
		input logic                    neg
	);
		logic signed [ACC_W+1:0] t;
		logic signed [ACC_W+1:0] sum;
		t = $signed({2'b00, mag});
		if (neg) begin
			t = -t;
		end
		sum = $signed({{2{acc[ACC_W-1]}}, acc}) + t;
		if ((sum[ACC_W+1] != sum[ACC_W-1]) || (sum[ACC_W] != sum[ACC_W-1])) begin
			return sum[ACC_W+1] ? SAT_LO : SAT_HI;
		end
		return sum[ACC_W-1:0];
	endfunction

endpackage

/* rtl/core/cdsf_div.sv */
// Bit-serial restoring divider with a capped 48-bit quotient magnitude.
module cdsf_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [cdsf_pkg::DIV_W-1:0]    num,
	input  logic [cdsf_pkg::DIV_W-1:0]    den,
	output cdsf_pkg::div_stat_t           stat,
	output logic [cdsf_pkg::ACC_W-1:0]    mag
);
	import cdsf_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_CHK  = 3'b010,
		DV_RUN  = 3'b100
	} dv_state_t;

	dv_state_t          st_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_W-1:0]   num_q;
	logic [DIV_W-1:0]   den_q;
	logic [DIV_W-1:0]   rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic [ACC_W-1:0]   mag_q;
	logic [DIV_W:0]     sh;
	logic [DIV_W:0]     diff;
	logic               ge;
	logic [QUO_W-1:0]   qn;
	logic               ovf;

	assign sh   = {rem_q, quo_q[QUO_W-1]};
	assign ge   = sh >= {1'b0, den_q};
	assign diff = sh - {1'b0, den_q};
	assign qn   = {quo_q[QUO_W-2:0], ge};
	assign ovf  = {{QUO_W{1'b0}}, num_q} >= {den_q, {QUO_W{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= DV_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= ((st_q == DV_CHK) && ovf) || ((st_q == DV_RUN) && (cnt_q == '0));
			unique case (st_q)
				DV_IDLE: begin
					if (start) begin
						st_q <= DV_CHK;
					end
				end
				DV_CHK: begin
					cnt_q <= CNT_W'(QUO_W - 1);
					if (ovf) begin
						st_q <= DV_IDLE;
					end else begin
						st_q <= DV_RUN;
					end
				end
				DV_RUN: begin
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						st_q <= DV_IDLE;
					end
				end
				default: st_q <= DV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			DV_IDLE: begin
				if (start) begin
					num_q <= num;
					den_q <= den;
				end
			end
			DV_CHK: begin
				rem_q <= DIV_W'(num_q[DIV_W-1:QUO_W]);
				quo_q <= num_q[QUO_W-1:0];
				if (ovf) begin
					mag_q <= MAG_CAP;
				end
			end
			DV_RUN: begin
				rem_q <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
				quo_q <= qn;
				if (cnt_q == '0) begin
					mag_q <= (qn > MAG_CAP) ? MAG_CAP : qn;
				end
			end
			default: ;
		endcase
	end

	assign stat.busy = (st_q != DV_IDLE);
	assign stat.done = done_q;
	assign mag       = mag_q;

endmodule

/* rtl/core/coulomb_direct_sum_forces_unit.sv */
// Top level of the direct-sum Coulomb energy and force unit.
//
// Input channel (s_*): one word per particle, position and charge; s_tlast marks
// the final particle of a set and starts the pair sums. Loading accepts one
// particle per cycle; particles beyond MAX_PARTICLES are dropped, a dropped word with
// s_tlast still starts the sums over the stored set.
// Output channel (m_*): one word per stored particle in load order, carrying the
// force vector, the set energy and a coincidence flag; m_tlast marks the final.
// Every unordered pair is visited once on one shared 34x34 multiplier, a
// one-bit-per-cycle square root and one serial divider (four quotients per pair);
// a pair at zero distance skips the root and the quotients. Results leave one
// word at a time: a new word is loaded only after the previous one is taken.
// s_tready is high only while loading; the next set may load while the final
// result still waits in the output register. A receiver stall holds the output
// word and halts the result sweep. Reset returns to loading with an empty set.
// Positions, charges and accumulated forces live in two synchronous memories.
`include "assert_macros.svh"

module coulomb_direct_sum_forces_unit #(
	parameter int MAX_PARTICLES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// pos_x, pos_y, pos_z, charge
	input  logic [cdsf_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// particle_index, force_x, force_y, force_z, total_energy, coincident_seen
	output logic [cdsf_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic                                m_tlast
);
	import cdsf_pkg::*;

	localparam int IW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
	localparam int CW = $clog2(MAX_PARTICLES + 1);

	typedef enum logic [22:0] {
		S_LOAD    = 23'h000001,
		S_ROW_RD  = 23'h000002,
		S_ROW_LD  = 23'h000004,
		S_PAIR_RD = 23'h000008,
		S_PAIR_LD = 23'h000010,
		S_SQ_X    = 23'h000020,
		S_SQ_Y    = 23'h000040,
		S_SQ_Z    = 23'h000080,
		S_SQ_SUM  = 23'h000100,
		S_SQRT    = 23'h000200,
		S_CUBE_A  = 23'h000400,
		S_CUBE_B  = 23'h000800,
		S_CUBE_C  = 23'h001000,
		S_CUBE_D  = 23'h002000,
		S_EDIV    = 23'h004000,
		S_EWAIT   = 23'h008000,
		S_FMUL    = 23'h010000,
		S_FDIV    = 23'h020000,
		S_FWAIT   = 23'h040000,
		S_PAIR_WB = 23'h080000,
		S_ROW_WB  = 23'h100000,
		S_OUT_RD  = 23'h200000,
		S_OUT_LD  = 23'h400000
	} state_t;

	state_t state_q, state_d;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] n_new;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [1:0]    axis_q;
	logic [5:0]    sq_cnt_q;
	logic          m_valid_q;

	logic [IN_TDATA_W-1:0]  pos_mem [MAX_PARTICLES];
	logic [3*ACC_W-1:0]     acc_mem [MAX_PARTICLES];
	logic [IN_TDATA_W-1:0]  pos_rd_q;
	logic [3*ACC_W-1:0]     acc_rd_q;
	logic                   pos_we, acc_we;
	logic [IW-1:0]          pos_raddr, acc_raddr, acc_waddr;
	logic [3*ACC_W-1:0]     acc_wdata;

	logic signed [POS_W-1:0]   xi_q, yi_q, zi_q;
	logic signed [CHG_W-1:0]   qi_q;
	logic signed [ACC_W-1:0]   fi_q [3];
	logic signed [ACC_W-1:0]   fj_q [3];
	logic signed [DELTA_W-1:0] delta_q [3];
	logic [DELTA_W-1:0]        dmag [3];
	logic [QM_W-1:0]           qm_q;
	logic                      qneg_q;
	logic signed [POS_W-1:0]   xj, yj, zj;
	logic signed [CHG_W-1:0]   qj;
	logic signed [2*CHG_W-1:0] qq;

	logic [D_W-1:0]   mul_a, mul_b;
	logic [P_W-1:0]   prod_q;
	logic [S_W-1:0]   s_q, s_sum;
	logic [P_W-1:0]   rad_q;
	logic [D_W+1:0]   rem_q;
	logic [D_W-1:0]   root_q;
	logic [D_W+3:0]   rem_sh, trial, rem_diff;
	logic             sq_ge;
	logic [D_W-1:0]   d2hi_q;
	logic [DIV_W-1:0] d3_q;

	logic                    div_start;
	logic [DIV_W-1:0]        div_num, div_den;
	div_stat_t               div_stat;
	logic [ACC_W-1:0]        div_mag;
	logic                    fneg;

	logic signed [ACC_W-1:0] energy_q;
	logic                    coin_q;
	logic [IDX_W-1:0]        m_idx_q;
	logic signed [ACC_W-1:0] m_fx_q, m_fy_q, m_fz_q, m_energy_q;
	logic                    m_coin_q, m_last_q;

	logic s_acc, j_last, i_last, k_last, keep;

	assign s_tready = (state_q == S_LOAD);
	assign s_acc    = s_tvalid && s_tready;
	assign keep     = cnt_q < CW'(MAX_PARTICLES);
	assign n_new    = keep ? cnt_q + CW'(1) : cnt_q;
	assign j_last   = CW'(j_q) == n_q - CW'(1);
	assign i_last   = CW'(i_q) == n_q - CW'(2);
	assign k_last   = CW'(k_q) == n_q - CW'(1);
	assign pos_we   = s_acc && keep;

	assign {qj, zj, yj, xj} = pos_rd_q;
	assign qq = qi_q * qj;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dmag[a] = delta_q[a][DELTA_W-1] ? DELTA_W'(-delta_q[a]) : DELTA_W'(delta_q[a]);
		end
	end

	assign s_sum    = s_q + S_W'(prod_q);
	assign rem_sh   = {rem_q, rad_q[P_W-1:P_W-2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign sq_ge    = rem_sh >= trial;
	assign rem_diff = rem_sh - trial;
	assign fneg     = qneg_q ^ delta_q[axis_q][DELTA_W-1];

	always_comb begin
		state_d   = state_q;
		pos_raddr = j_q;
		acc_raddr = j_q;
		acc_we    = 1'b0;
		acc_waddr = j_q;
		acc_wdata = {fj_q[2], fj_q[1], fj_q[0]};
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = DIV_W'({qm_q, 24'b0});
		div_den   = DIV_W'(root_q);
		unique case (state_q)
			S_LOAD: begin
				if (s_acc && s_tlast) begin
					state_d = (n_new == CW'(1)) ? S_OUT_RD : S_ROW_RD;
				end
			end
			S_ROW_RD: begin
				pos_raddr = i_q;
				acc_raddr = i_q;
				state_d   = S_ROW_LD;
			end
			S_ROW_LD:  state_d = S_PAIR_RD;
			S_PAIR_RD: state_d = S_PAIR_LD;
			S_PAIR_LD: state_d = S_SQ_X;
			S_SQ_X: begin
				mul_a   = D_W'(dmag[0]);
				mul_b   = D_W'(dmag[0]);
				state_d = S_SQ_Y;
			end
			S_SQ_Y: begin
				mul_a   = D_W'(dmag[1]);
				mul_b   = D_W'(dmag[1]);
				state_d = S_SQ_Z;
			end
			S_SQ_Z: begin
				mul_a   = D_W'(dmag[2]);
				mul_b   = D_W'(dmag[2]);
				state_d = S_SQ_SUM;
			end
			S_SQ_SUM: state_d = (s_sum == '0) ? S_PAIR_WB : S_SQRT;
			S_SQRT: begin
				if (sq_cnt_q == '0) begin
					state_d = S_CUBE_A;
				end
			end
			S_CUBE_A: begin
				mul_a   = root_q;
				mul_b   = root_q;
				state_d = S_CUBE_B;
			end
			S_CUBE_B: begin
				mul_a   = prod_q[D_W-1:0];
				mul_b   = root_q;
				state_d = S_CUBE_C;
			end
			S_CUBE_C: begin
				mul_a   = d2hi_q;
				mul_b   = root_q;
				state_d = S_CUBE_D;
			end
			S_CUBE_D: state_d = S_EDIV;
			S_EDIV: begin
				div_start = 1'b1;
				state_d   = S_EWAIT;
			end
			S_EWAIT: begin
				if (div_stat.done) begin
					state_d = S_FMUL;
				end
			end
			S_FMUL: begin
				mul_a   = D_W'(qm_q);
				mul_b   = D_W'(dmag[axis_q]);
				state_d = S_FDIV;
			end
			S_FDIV: begin
				div_start = 1'b1;
				div_num   = {prod_q[61:0], 40'b0};
				div_den   = d3_q;
				state_d   = S_FWAIT;
			end
			S_FWAIT: begin
				if (div_stat.done) begin
					state_d = (axis_q == 2'd2) ? S_PAIR_WB : S_FMUL;
				end
			end
			S_PAIR_WB: begin
				acc_we  = 1'b1;
				state_d = j_last ? S_ROW_WB : S_PAIR_RD;
			end
			S_ROW_WB: begin
				acc_we    = 1'b1;
				acc_waddr = i_q;
				acc_wdata = {fi_q[2], fi_q[1], fi_q[0]};
				state_d   = i_last ? S_OUT_RD : S_ROW_RD;
			end
			S_OUT_RD: begin
				acc_raddr = k_q;
				if (!m_valid_q) begin
					state_d = S_OUT_LD;
				end
			end
			S_OUT_LD: state_d = k_last ? S_LOAD : S_OUT_RD;
			default:  state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[cnt_q[IW-1:0]] <= s_tdata;
		end
		pos_rd_q <= pos_mem[pos_raddr];
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[acc_waddr] <= acc_wdata;
		end
		acc_rd_q <= acc_mem[acc_raddr];
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	cdsf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.mag    (div_mag)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_LOAD;
			cnt_q     <= '0;
			n_q       <= '0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			axis_q    <= '0;
			sq_cnt_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			m_valid_q <= (state_q == S_OUT_LD) || (m_valid_q && !m_tready);
			case (state_q)
				S_LOAD: begin
					if (s_acc) begin
						if (s_tlast) begin
							cnt_q <= '0;
							n_q   <= n_new;
							i_q   <= '0;
							k_q   <= '0;
						end else begin
							cnt_q <= n_new;
						end
					end
				end
				S_ROW_LD:  j_q <= i_q + IW'(1);
				S_SQ_SUM:  sq_cnt_q <= 6'd33;
				S_SQRT:    sq_cnt_q <= sq_cnt_q - 6'd1;
				S_EWAIT: begin
					if (div_stat.done) begin
						axis_q <= '0;
					end
				end
				S_FWAIT: begin
					if (div_stat.done) begin
						axis_q <= axis_q + 2'd1;
					end
				end
				S_PAIR_WB: j_q <= j_q + IW'(1);
				S_ROW_WB:  i_q <= i_q + IW'(1);
				S_OUT_LD:  k_q <= k_q + IW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				if (s_acc && s_tlast) begin
					energy_q <= '0;
					coin_q   <= 1'b0;
				end
			end
			S_ROW_LD: begin
				{qi_q, zi_q, yi_q, xi_q} <= pos_rd_q;
				for (int a = 0; a < 3; a++) begin
					fi_q[a] <= (i_q == '0) ? '0 : acc_rd_q[a*ACC_W +: ACC_W];
				end
			end
			S_PAIR_LD: begin
				delta_q[0] <= $signed({xi_q[POS_W-1], xi_q}) - $signed({xj[POS_W-1], xj});
				delta_q[1] <= $signed({yi_q[POS_W-1], yi_q}) - $signed({yj[POS_W-1], yj});
				delta_q[2] <= $signed({zi_q[POS_W-1], zi_q}) - $signed({zj[POS_W-1], zj});
				qm_q       <= qq[2*CHG_W-1] ? QM_W'(-qq) : QM_W'(qq);
				qneg_q     <= qq[2*CHG_W-1];
				for (int a = 0; a < 3; a++) begin
					fj_q[a] <= (i_q == '0) ? '0 : acc_rd_q[a*ACC_W +: ACC_W];
				end
			end
			S_SQ_Y: s_q <= S_W'(prod_q);
			S_SQ_Z: s_q <= s_sum;
			S_SQ_SUM: begin
				if (s_sum == '0) begin
					coin_q <= 1'b1;
				end
				rad_q  <= {2'b00, s_sum};
				rem_q  <= '0;
				root_q <= '0;
			end
			S_SQRT: begin
				rad_q  <= {rad_q[P_W-3:0], 2'b00};
				rem_q  <= sq_ge ? rem_diff[D_W+1:0] : rem_sh[D_W+1:0];
				root_q <= {root_q[D_W-2:0], sq_ge};
			end
			S_CUBE_B: d2hi_q <= prod_q[P_W-1:D_W];
			S_CUBE_C: d3_q   <= DIV_W'(prod_q);
			S_CUBE_D: d3_q   <= d3_q + {prod_q, {D_W{1'b0}}};
			S_EWAIT: begin
				if (div_stat.done) begin
					energy_q <= sat_add(energy_q, div_mag, qneg_q);
				end
			end
			S_FWAIT: begin
				if (div_stat.done) begin
					fi_q[axis_q] <= sat_add(fi_q[axis_q], div_mag, fneg);
					fj_q[axis_q] <= sat_add(fj_q[axis_q], div_mag, !fneg);
				end
			end
			S_OUT_LD: begin
				m_idx_q    <= IDX_W'(k_q);
				m_fx_q     <= (n_q == CW'(1)) ? '0 : acc_rd_q[0 +: ACC_W];
				m_fy_q     <= (n_q == CW'(1)) ? '0 : acc_rd_q[ACC_W +: ACC_W];
				m_fz_q     <= (n_q == CW'(1)) ? '0 : acc_rd_q[2*ACC_W +: ACC_W];
				m_energy_q <= energy_q;
				m_coin_q   <= coin_q;
				m_last_q   <= k_last;
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_coin_q, m_energy_q, m_fz_q, m_fy_q, m_fx_q, m_idx_q};
	assign m_tlast  = m_last_q;

	`CDSF_ASSERT(a_div_idle, div_start, !div_stat.busy, "divider started while busy")
	`CDSF_ASSERT(a_out_free, state_q == S_OUT_LD, !m_valid_q, "output word overwritten")
	`CDSF_ASSERT(a_cnt_range, s_tready, cnt_q <= CW'(MAX_PARTICLES), "load count out of range")
	`CDSF_ASSERT(a_pair_order, state_q == S_PAIR_RD, j_q > i_q, "pair visited out of order")
	`CDSF_ASSERT_NEXT(a_load_back, (state_q == S_OUT_LD) && k_last, s_tready, "load not resumed")

endmodule

/* tb/cdsf_checker.sv */
// Checker for the Coulomb force unit: predicts per-particle forces and energy, compares results.
module cdsf_checker
	import cdsf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tlast,
	output int                     errors,
	output int                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 64;

	typedef struct packed {
		logic [IDX_W-1:0]        idx;
		logic signed [ACC_W-1:0] fx;
		logic signed [ACC_W-1:0] fy;
		logic signed [ACC_W-1:0] fz;
		logic signed [ACC_W-1:0] energy;
		logic                    coincident;
		logic                    last;
	} force_word_t;

	logic signed [POS_W-1:0] pos_x [SLOTS];
	logic signed [POS_W-1:0] pos_y [SLOTS];
	logic signed [POS_W-1:0] pos_z [SLOTS];
	logic signed [CHG_W-1:0] chg [SLOTS];
	logic signed [ACC_W-1:0] acc_x [SLOTS];
	logic signed [ACC_W-1:0] acc_y [SLOTS];
	logic signed [ACC_W-1:0] acc_z [SLOTS];
	logic signed [ACC_W-1:0] energy_sum;
	logic                    coincident_hit;
	int                      count;
	force_word_t             expected_forces [$];

	assign pending = expected_forces.size();

	function automatic logic signed [ACC_W-1:0] clamp_sum(logic signed [ACC_W-1:0] a,
			logic signed [63:0] t);
		logic signed [63:0] s;
		s = 64'(a) + t;
		if (s > 64'sh7FFF_FFFF_FFFF) return SAT_HI;
		if (s < -64'sh8000_0000_0000) return SAT_LO;
		return s[ACC_W-1:0];
	endfunction

	function automatic logic [63:0] floor_root(logic [127:0] s);
		logic [63:0]  r;
		logic [127:0] c;
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (s >= c * c) r = c[63:0];
		end
		return r;
	endfunction

	function automatic logic signed [63:0] axis_force(logic [63:0] qm, logic qneg,
			logic signed [32:0] delta, logic [127:0] d3);
		logic [32:0]  ad;
		logic [127:0] num;
		logic [127:0] q;
		logic [63:0]  mag;
		ad = delta < 0 ? -delta : delta;
		num = (128'(qm) * 128'(ad)) << 40;
		q = num / d3;
		mag = (q > 128'h8000_0000_0000) ? 64'h8000_0000_0000 : q[63:0];
		return (qneg != (delta < 0)) ? -$signed(mag) : $signed(mag);
	endfunction

	task automatic add_pair(int i, int j);
		logic signed [32:0] dx, dy, dz;
		logic [32:0]        ax, ay, az;
		logic [127:0]       s, d3;
		logic [63:0]        d, qm, em;
		logic signed [31:0] qq;
		logic signed [63:0] t;
		logic               qneg;
		dx = pos_x[i] - pos_x[j];
		dy = pos_y[i] - pos_y[j];
		dz = pos_z[i] - pos_z[j];
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		az = dz < 0 ? -dz : dz;
		s = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
		if (s == 0) begin
			coincident_hit = 1'b1;
			return;
		end
		d = floor_root(s);
		qq = chg[i] * chg[j];
		qneg = qq < 0;
		qm = qneg ? 64'(-64'(qq)) : 64'(qq);
		em = (qm << 24) / d;
		if (em > 64'h8000_0000_0000) em = 64'h8000_0000_0000;
		energy_sum = clamp_sum(energy_sum, qneg ? -$signed(em) : $signed(em));
		d3 = 128'(d) * 128'(d) * 128'(d);
		t = axis_force(qm, qneg, dx, d3);
		acc_x[i] = clamp_sum(acc_x[i], t);
		acc_x[j] = clamp_sum(acc_x[j], -t);
		t = axis_force(qm, qneg, dy, d3);
		acc_y[i] = clamp_sum(acc_y[i], t);
		acc_y[j] = clamp_sum(acc_y[j], -t);
		t = axis_force(qm, qneg, dz, d3);
		acc_z[i] = clamp_sum(acc_z[i], t);
		acc_z[j] = clamp_sum(acc_z[j], -t);
	endtask

	task automatic sum_set();
		force_word_t w;
		for (int i = 0; i < count; i++) begin
			acc_x[i] = 0;
			acc_y[i] = 0;
			acc_z[i] = 0;
		end
		energy_sum = 0;
		coincident_hit = 1'b0;
		for (int i = 0; i < count; i++)
			for (int j = i + 1; j < count; j++)
				add_pair(i, j);
		for (int i = 0; i < count; i++) begin
			w.idx = i[IDX_W-1:0];
			w.fx = acc_x[i];
			w.fy = acc_y[i];
			w.fz = acc_z[i];
			w.energy = energy_sum;
			w.coincident = coincident_hit;
			w.last = (i == count - 1);
			expected_forces.push_back(w);
		end
		count = 0;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			count = 0;
		end else if (s_tvalid && s_tready) begin
			if (count < SLOTS) begin
				pos_x[count] = s_tdata[31:0];
				pos_y[count] = s_tdata[63:32];
				pos_z[count] = s_tdata[95:64];
				chg[count] = s_tdata[111:96];
				count++;
			end
			if (s_tlast) sum_set();
		end
	end

	always @(posedge clk) begin
		force_word_t w, a;
		if (!arst_n) begin
			errors = 0;
		end else if (m_tvalid && m_tready) begin
			a.idx = m_tdata[5:0];
			a.fx = m_tdata[53:6];
			a.fy = m_tdata[101:54];
			a.fz = m_tdata[149:102];
			a.energy = m_tdata[197:150];
			a.coincident = m_tdata[198];
			a.last = m_tlast;
			if (expected_forces.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result word idx=%0d", a.idx);
			end else begin
				w = expected_forces.pop_front();
				if (w != a) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch exp idx=%0d f=%0d/%0d/%0d e=%0d c=%0b l=%0b",
							w.idx, w.fx, w.fy, w.fz, w.energy, w.coincident, w.last);
						$display("         got idx=%0d f=%0d/%0d/%0d e=%0d c=%0b l=%0b",
							a.idx, a.fx, a.fy, a.fz, a.energy, a.coincident, a.last);
					end
				end
			end
		end
	end

endmodule

/* tb/tb_top.sv */
// Top of the Coulomb force unit testbench: clock, reset, particle stimulus and verdict.
module tb_top;
	import cdsf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	int                     errors;
	int                     pending;
	int                     rx_hold = 0;
	bit                     rx_calm = 1'b0;
	bit                     tx_calm = 1'b0;

	always #5 clk = ~clk;

	coulomb_direct_sum_forces_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	cdsf_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.errors(errors), .pending(pending)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if ($urandom_range(0, 499) == 0) rx_calm <= !rx_calm;
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
			rx_hold <= pick_gap();
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_particle(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			logic [15:0] q, logic last);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {q, z, y, x};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [31:0] near_coord(logic [31:0] base);
		return base + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
	endfunction

	task automatic send_random_set(int n);
		logic [31:0] bx, by, bz, x, y, z;
		int k;
		bx = $urandom();
		by = $urandom();
		bz = $urandom();
		x = bx;
		y = by;
		z = bz;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			if (k < 60) begin
				x = near_coord(bx);
				y = near_coord(by);
				z = near_coord(bz);
			end else if (k < 85) begin
				x = $urandom();
				y = $urandom();
				z = $urandom();
			end
			send_particle(x, y, z, 16'($urandom()), i == n - 1);
		end
	endtask

	initial begin
		#40ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		logic [31:0] ax, ay, az, bx, by, bz;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_particle(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 1'b1);
		send_particle(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 1'b0);
		send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 1'b1);
		send_particle(32'h0, 32'h0, 32'h0, 16'h0100, 1'b0);
		send_particle(32'h0, 32'h0, 32'h0, 16'h0100, 1'b0);
		send_particle(32'h0001_0000, 32'h0, 32'h0, 16'hFF00, 1'b1);
		send_particle(32'h0, 32'h0, 32'h0, 16'h7FFF, 1'b0);
		send_particle(32'h1, 32'h0, 32'h0, 16'h7FFF, 1'b0);
		send_particle(32'h1, 32'h1, 32'h0, 16'h7FFF, 1'b0);
		send_particle(32'h0, 32'h1, 32'h1, 16'h0, 1'b1);
		send_particle(32'h0, 32'h0, 32'h0, 16'h8000, 1'b0);
		send_particle(32'h0, 32'h0, 32'h0005_0000, 16'h8000, 1'b0);
		send_particle(32'hFFFF_FFFF, 32'h0, 32'hFFFB_0000, 16'hFFFF, 1'b1);

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);

		ax = $urandom();
		ay = $urandom();
		az = $urandom();
		bx = $urandom();
		by = $urandom();
		bz = $urandom();
		for (int i = 0; i < 66; i++) begin
			if (i[0])
				send_particle(bx, by, bz, 16'($urandom()), i == 65);
			else
				send_particle(ax, ay, az, 16'($urandom()), 1'b0);
		end

		for (int sent = 0; sent < 40; ) begin
			int n;
			n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
			tx_calm = ($urandom_range(0, 4) == 0);
			send_random_set(n);
			sent += n;
		end
		s_tvalid <= 1'b0;
		s_tlast <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
